// ----- sv/plst_pkg.sv -----
// Package for the positional list store: operation codes and the cell command.
`timescale 1ns / 1ps
`default_nettype none
package plst_pkg;

  // Index fields are carried at the width of the largest depth (256 entries); entry_count is only 5 bits
  localparam int unsigned NDX_W   = 9;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_DEL_LAST  = 3'd2,
    MODE_DEL_AT    = 3'd3,
    MODE_READ_AT   = 3'd4,
    MODE_READ_LAST = 3'd5
  } mode_t;

  // Broadcast to every cell.
  //   ins:  load data_word at 'at'; cells in (at, last] take the left neighbor
  //   del:  cells in [at, last-2] take the right neighbor
  //   rd:   cell 'at' drives its word onto the read bus
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [NDX_W-1:0] at;
    logic [NDX_W-1:0] last;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ----- sv/plst_cell.sv -----
// One cell of the list chain: holds one entry and shifts it to or from its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module plst_cell #(
  parameter int unsigned INDEX      = 0,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire plst_pkg::cell_cmd_t     cmd,
  input  wire logic [WORD_WIDTH-1:0]   data_word,
  input  wire logic [WORD_WIDTH-1:0]   left_word,
  input  wire logic [WORD_WIDTH-1:0]   right_word,
  output logic      [WORD_WIDTH-1:0]   word,
  output logic      [WORD_WIDTH-1:0]   rd_word
);

  localparam logic [plst_pkg::NDX_W-1:0] IDX = plst_pkg::NDX_W'(INDEX);
  localparam logic [plst_pkg::NDX_W:0]   IDX_P1 = (plst_pkg::NDX_W+1)'(INDEX + 1);

  logic [WORD_WIDTH-1:0] word_next;

  always_comb begin
    word_next = word;
    if (cmd.ins) begin
      if (IDX == cmd.at) begin
        word_next = data_word;
      end else if (IDX > cmd.at && IDX <= cmd.last) begin
        word_next = left_word;
      end
    end else if (cmd.del) begin
      if (IDX >= cmd.at && IDX_P1 < {1'b0, cmd.last}) begin
        word_next = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  assign rd_word = (cmd.rd && IDX == cmd.at) ? word : '0;

endmodule
`default_nettype wire

// ----- sv/positional_list_store_unit.sv -----
// Positional list store: a bounded ordered list of words kept in a chain of cells.
// Usage:
//   Input channel (in_valid/in_ready) carries one command word: mode, position,
//   data_word. Modes: append, insert at position (appends past the end), delete
//   last, delete at position, read at position, read last.
//   Output channel (out_valid/out_ready) returns one word per command: status
//   (1 = error: empty, out of range, full or unused mode), read_word (zero unless
//   a successful read) and entry_count after the command.
// Timing:
//   One command per cycle while the receiver keeps up. The result is registered and shows up
//   in the cycle after the command is accepted. Inserts and deletes shift every later
//   cell at once in that same cycle. in_ready stays high while the output register
//   is empty or being drained, so a stalled receiver holds back at most one result
//   and then stalls the sender.
// Reset:
//   rst (synchronous) empties the list and the output register. Cell contents are
//   not cleared; only entries below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module positional_list_store_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [plst_pkg::MODE_W-1:0]   mode,
  input  wire logic [plst_pkg::POS_W-1:0]    position,
  input  wire logic [WORD_WIDTH-1:0]         data_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               status,
  output logic      [WORD_WIDTH-1:0]         read_word,
  output logic      [plst_pkg::COUNT_W-1:0]  entry_count
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [plst_pkg::NDX_W-1:0] DEPTH_N = plst_pkg::NDX_W'(DEPTH);

  logic [CW-1:0]               count;
  logic [CW-1:0]               count_next;
  logic [plst_pkg::NDX_W-1:0]  cnt_n;
  logic [plst_pkg::NDX_W-1:0]  pos_n;
  logic [plst_pkg::NDX_W-1:0]  cnt_after;
  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        ok;
  logic                        is_read;
  plst_pkg::cell_cmd_t         cmd;
  plst_pkg::cell_cmd_t         op;
  logic [WORD_WIDTH-1:0]       cell_word [DEPTH];
  logic [WORD_WIDTH-1:0]       cell_rd   [DEPTH];
  logic [WORD_WIDTH-1:0]       rd_bus;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cnt_n = plst_pkg::NDX_W'(count);
  assign pos_n = plst_pkg::NDX_W'(position);
  assign full  = (cnt_n == DEPTH_N);
  assign empty = (cnt_n == '0);

  // decode the command, ignoring whether it is accepted
  always_comb begin
    op      = '0;
    op.last = cnt_n;
    ok      = 1'b0;
    is_read = 1'b0;
    case (mode)
      plst_pkg::MODE_APPEND: begin
        ok     = !full;
        op.ins = ok;
        op.at  = cnt_n;
      end
      plst_pkg::MODE_INSERT: begin
        ok     = !full;
        op.ins = ok;
        op.at  = (pos_n > cnt_n) ? cnt_n : pos_n;
      end
      plst_pkg::MODE_DEL_LAST: begin
        ok     = !empty;
        op.del = ok;
        op.at  = cnt_n - 1'b1;
      end
      plst_pkg::MODE_DEL_AT: begin
        ok     = pos_n < cnt_n;
        op.del = ok;
        op.at  = pos_n;
      end
      plst_pkg::MODE_READ_AT: begin
        ok      = pos_n < cnt_n;
        is_read = 1'b1;
        op.rd   = ok;
        op.at   = pos_n;
      end
      plst_pkg::MODE_READ_LAST: begin
        ok      = !empty;
        is_read = 1'b1;
        op.rd   = ok;
        op.at   = cnt_n - 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd     = op;
    cmd.ins = op.ins && accept;
    cmd.del = op.del && accept;
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_WIDTH-1:0] left_word;
      logic [WORD_WIDTH-1:0] right_word;
      if (gi == 0) begin : g_first
        assign left_word = data_word;
      end else begin : g_mid_l
        assign left_word = cell_word[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_word = '0;
      end else begin : g_mid_r
        assign right_word = cell_word[gi+1];
      end
      plst_cell #(
        .INDEX      (gi),
        .WORD_WIDTH (WORD_WIDTH)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .data_word  (data_word),
        .left_word  (left_word),
        .right_word (right_word),
        .word       (cell_word[gi]),
        .rd_word    (cell_rd[gi])
      );
    end
  endgenerate

  // at most one cell drives a nonzero word
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.del) begin
      count_next = count - 1'b1;
    end
  end

  assign cnt_after = plst_pkg::NDX_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= !ok;
      read_word   <= (ok && is_read) ? rd_bus : '0;
      entry_count <= cnt_after[plst_pkg::COUNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    plst_pkg::NDX_W'(count) <= DEPTH_N)
    else $error("entry count above depth");

  a_ins_del_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins && cmd.del))
    else $error("insert and delete together");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins |=> count == CW'($past(count) + 1'b1))
    else $error("insert did not bump count");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_word == '0)
    else $error("error result with nonzero read word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("pending result dropped");
`endif

endmodule
`default_nettype wire

// ----- test/positional_list_store_unit_test.sv -----
// Testbench for the positional list store: checks command words against a queue-based list shadow.
`timescale 1ns / 1ps
module positional_list_store_unit_test;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned RANDOM_WORDS = 700;
  localparam int unsigned CALM_WORDS   = 100;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // codes the block rejects as unused modes
  localparam logic [plst_pkg::MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [plst_pkg::MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic                         status;
    logic [WORD_W-1:0]            read_word;
    logic [plst_pkg::COUNT_W-1:0] entry_count;
  } list_result_t;

  class list_shadow;
    logic [WORD_W-1:0] words[$];
    list_result_t      due_results[$];
    int unsigned       errors = 0;

    function int unsigned size();
      return words.size();
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t: %s", $time, msg);
    endfunction

    // apply one accepted command word to the shadow list and queue its result
    function void apply_command(logic [plst_pkg::MODE_W-1:0] m,
                                logic [plst_pkg::POS_W-1:0] p,
                                logic [WORD_W-1:0] d);
      list_result_t r;
      int unsigned n;
      n = words.size();
      r.status = 1'b1;
      r.read_word = '0;
      case (m)
        plst_pkg::MODE_APPEND: if (n < DEPTH) begin
          words.push_back(d);
          r.status = 1'b0;
        end
        plst_pkg::MODE_INSERT: if (n < DEPTH) begin
          // a position past the end appends
          if (p >= n) words.push_back(d);
          else words.insert(p, d);
          r.status = 1'b0;
        end
        plst_pkg::MODE_DEL_LAST: if (n > 0) begin
          void'(words.pop_back());
          r.status = 1'b0;
        end
        plst_pkg::MODE_DEL_AT: if (p < n) begin
          words.delete(p);
          r.status = 1'b0;
        end
        plst_pkg::MODE_READ_AT: if (p < n) begin
          r.read_word = words[p];
          r.status = 1'b0;
        end
        plst_pkg::MODE_READ_LAST: if (n > 0) begin
          r.read_word = words[n-1];
          r.status = 1'b0;
        end
        default: ;
      endcase
      r.entry_count = plst_pkg::COUNT_W'(words.size());
      due_results.push_back(r);
    endfunction

    function void check_result(logic st, logic [WORD_W-1:0] rw,
                               logic [plst_pkg::COUNT_W-1:0] ec);
      list_result_t e;
      if (due_results.size() == 0) begin
        flag($sformatf("result with nothing due: status %0b read_word %h count %0d",
                       st, rw, ec));
        return;
      end
      e = due_results.pop_front();
      if (st !== e.status)
        flag($sformatf("status: expected %0b, got %0b", e.status, st));
      if (rw !== e.read_word)
        flag($sformatf("read_word: expected %h, got %h", e.read_word, rw));
      if (ec !== e.entry_count)
        flag($sformatf("entry_count: expected %0d, got %0d", e.entry_count, ec));
    endfunction
  endclass

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  logic [plst_pkg::MODE_W-1:0]  mode;
  logic [plst_pkg::POS_W-1:0]   position;
  logic [WORD_W-1:0]            data_word;
  logic                         out_valid;
  logic                         out_ready;
  logic                         status;
  logic [WORD_W-1:0]            read_word;
  logic [plst_pkg::COUNT_W-1:0] entry_count;

  bit          calm = 1'b0;
  int unsigned cycles = 0;
  list_shadow  shadow = new();

  positional_list_store_unit #(
    .DEPTH(DEPTH),
    .WORD_WIDTH(WORD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position(position),
    .data_word(data_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .read_word(read_word),
    .entry_count(entry_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("positional_list_store_unit_test: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      shadow.check_result(status, read_word, entry_count);
  end

  // receiver: random stall bursts, none once the run goes calm
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [plst_pkg::MODE_W-1:0] m,
                           input logic [plst_pkg::POS_W-1:0] p,
                           input logic [WORD_W-1:0] d);
    in_valid <= 1'b1;
    mode <= m;
    position <= p;
    data_word <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.apply_command(m, p, d);
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // growing phases favor adds, shrinking phases favor deletes, so the list
  // swings between empty and full many times
  task automatic random_word(input bit growing);
    logic [plst_pkg::MODE_W-1:0] m;
    logic [plst_pkg::POS_W-1:0]  p;
    logic [WORD_W-1:0]           d;
    int unsigned                 pick;
    int unsigned                 n;
    n = shadow.size();
    pick = $urandom_range(0, 99);
    if (pick < 3)
      m = $urandom_range(0, 1) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
    else if (pick < (growing ? 55 : 20))
      m = $urandom_range(0, 1) ? plst_pkg::MODE_APPEND : plst_pkg::MODE_INSERT;
    else if (pick < (growing ? 70 : 65))
      m = $urandom_range(0, 1) ? plst_pkg::MODE_DEL_LAST : plst_pkg::MODE_DEL_AT;
    else
      m = $urandom_range(0, 1) ? plst_pkg::MODE_READ_AT : plst_pkg::MODE_READ_LAST;
    if ($urandom_range(0, 7) == 0) p = plst_pkg::POS_W'($urandom_range(0, 255));
    else p = plst_pkg::POS_W'($urandom_range(0, n));
    case ($urandom_range(0, 9))
      0: d = '0;
      1: d = '1;
      default: d = $urandom;
    endcase
    send_word(m, p, d);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = plst_pkg::MODE_APPEND;
    position = '0;
    data_word = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty list: every remove and read fails, unused modes fail
    send_word(plst_pkg::MODE_READ_LAST, 8'd0, '0);
    send_word(plst_pkg::MODE_READ_AT, 8'd0, '0);
    send_word(plst_pkg::MODE_DEL_LAST, 8'd0, '0);
    send_word(plst_pkg::MODE_DEL_AT, 8'd255, '0);
    send_word(MODE_UNUSED_LO, 8'd255, '1);
    send_word(MODE_UNUSED_HI, 8'd0, '1);

    send_word(plst_pkg::MODE_APPEND, 8'd0, '0);
    send_word(plst_pkg::MODE_APPEND, 8'd0, '1);
    send_word(plst_pkg::MODE_INSERT, 8'd0, 32'ha5a5_a5a5);
    send_word(plst_pkg::MODE_INSERT, 8'd255, 32'h1234_5678);   // past the end: appends
    send_word(plst_pkg::MODE_INSERT, 8'd1, 32'h5a5a_5a5a);
    send_word(plst_pkg::MODE_READ_AT, 8'd0, '0);
    send_word(plst_pkg::MODE_READ_AT, 8'd4, '0);
    send_word(plst_pkg::MODE_DEL_AT, 8'd5, '0);                 // index equal to count
    send_word(plst_pkg::MODE_DEL_AT, 8'd1, '0);
    send_word(plst_pkg::MODE_READ_LAST, 8'd0, '0);
    send_word(plst_pkg::MODE_DEL_LAST, 8'd0, '0);

    // fill up, then hit the full list
    while (shadow.size() < DEPTH)
      send_word(shadow.size() % 2 ? plst_pkg::MODE_APPEND : plst_pkg::MODE_INSERT,
                plst_pkg::POS_W'($urandom_range(0, 255)), $urandom);
    send_word(plst_pkg::MODE_APPEND, 8'd0, '1);
    send_word(plst_pkg::MODE_INSERT, 8'd0, '1);
    send_word(plst_pkg::MODE_READ_AT, 8'd15, '0);
    send_word(plst_pkg::MODE_DEL_AT, 8'd15, '0);

    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS - CALM_WORDS) calm = 1'b1;
      if (k % 150 == 75) drain_results();
      maybe_pause();
      random_word((k / 60) % 2 == 0);
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (shadow.errors == 0)
      $display("positional_list_store_unit_test: clean");
    else
      $display("positional_list_store_unit_test: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/plst_pkg.sv
sv/plst_cell.sv
sv/positional_list_store_unit.sv
test/positional_list_store_unit_test.sv
